/* rtl/core/nzp_pkg.sv */
// ----------------------------------------------------------------------------
// Nested zone profiler package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package nzp_pkg;

  localparam int ZONE_ID_W = 10;
  localparam int TIME_W    = 64;
  localparam int DEPTH_W   = 7;
  localparam int IN_DATA_W = 144;
  localparam int OUT_DATA_W = 280;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_END   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_CUR_WR,
    S_PAR_STK,
    S_PAR_ZONE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               seen;
    logic [DEPTH_W-1:0] level;
    logic [TIME_W-1:0]  bytes;
    logic [TIME_W-1:0]  hits;
    logic [TIME_W-1:0]  excl;
    logic [TIME_W-1:0]  incl;
  } zent_t;

  typedef struct packed {
    logic    clr_wr;
    logic    accept;
    logic    eval;
    status_t code;
    logic    push;
    logic    pop;
    logic    cur_wr;
    logic    par_zone_rd;
    logic    par_wr;
    logic    out_load;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic mismatch;
    logic has_parent;
    logic out_free;
    logic clr_last;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/nested_zone_time_profiler_top.sv */
// ----------------------------------------------------------------------------
// Nested zone time profiler
// Begin/end/read events on nested zones update per-zone timing counters.
// ----------------------------------------------------------------------------
// Each input beat carries a command in in_tuser and the zone, byte count and
// timestamp in in_tdata. Every beat produces exactly one result beat on the
// out_ channel with a status, the zone counters (read only) and the depth.
// The block handles one event at a time. A begin, read, failed end or unused
// command loads the result register after evaluation; a matched end first
// writes its own zone counters and, when a parent frame exists, reads the
// parent zone and then writes it before the result is loaded. The next beat
// is accepted only after the result is loaded. The steps are set by the zone
// counter memory, which is read and written once per zone touched, plus one
// stack read for the parent frame.
// After reset the zone memory is cleared one entry per cycle, all NUM_ZONES
// entries, and in_tready stays low until the pass ends. The result sits in an
// output register; if the receiver stalls, the finished event waits there and
// the next event is held off only once its own result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module nested_zone_time_profiler_top
  import nzp_pkg::*;
#(
  parameter int NUM_ZONES   = 1024,
  parameter int MAX_NESTING = 64
) (
  input  wire  logic                  clk,
  input  wire  logic                  rst_n,
  input  wire  logic                  in_tvalid,
  output logic                        in_tready,
  // zone_id[9:0], byte_cnt[73:10], timestamp[137:74], zero pad
  input  wire  logic [IN_DATA_W-1:0]  in_tdata,
  // command[1:0]
  input  wire  logic [1:0]            in_tuser,
  output logic                        out_tvalid,
  input  wire  logic                  out_tready,
  // status[1:0], hits[65:2], exclusive_time[129:66], inclusive_time[193:130],
  // bytes_total[257:194], first_level[264:258], was_seen[265],
  // open_levels[272:266], zero pad
  output logic [OUT_DATA_W-1:0]       out_tdata
);

  ctl_t ctl;
  sts_t sts;

  nzp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  nzp_datapath #(
    .NUM_ZONES   (NUM_ZONES),
    .MAX_NESTING (MAX_NESTING)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_cmd    (in_tuser),
    .in_data   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

/* rtl/core/nzp_ctrl.sv */
// ----------------------------------------------------------------------------
// Nested zone profiler controller
// Sequences the clearing pass and the memory steps of each event.
// ----------------------------------------------------------------------------
`default_nettype none

module nzp_ctrl
  import nzp_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic in_valid,
  output logic       in_ready,
  input  wire  sts_t sts,
  output ctl_t       ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ctl.code  = ST_OK;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        ctl.eval  = 1'b1;
        state_nxt = S_DONE;
        unique case (sts.cmd)
          CMD_BEGIN: begin
            if (sts.full) begin
              ctl.code = ST_FULL;
            end else begin
              ctl.push = 1'b1;
            end
          end
          CMD_END: begin
            if (sts.empty) begin
              ctl.code = ST_EMPTY;
            end else if (sts.mismatch) begin
              ctl.code = ST_MISMATCH;
            end else begin
              ctl.pop   = 1'b1;
              state_nxt = S_CUR_WR;
            end
          end
          CMD_READ, CMD_NONE: begin
            ctl.code = ST_OK;
          end
          default: begin
            ctl.code = ST_OK;
          end
        endcase
      end
      S_CUR_WR: begin
        ctl.cur_wr = 1'b1;
        state_nxt  = sts.has_parent ? S_PAR_STK : S_DONE;
      end
      S_PAR_STK: begin
        ctl.par_zone_rd = 1'b1;
        state_nxt       = S_PAR_ZONE;
      end
      S_PAR_ZONE: begin
        ctl.par_wr = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/nzp_datapath.sv */
// ----------------------------------------------------------------------------
// Nested zone profiler datapath
// Zone counter memory, frame stack memory, time arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nzp_datapath
  import nzp_pkg::*;
#(
  parameter int NUM_ZONES   = 1024,
  parameter int MAX_NESTING = 64
) (
  input  wire  logic                  clk,
  input  wire  logic                  rst_n,
  input  wire  ctl_t                  ctl,
  output sts_t                        sts,
  input  wire  logic [1:0]            in_cmd,
  input  wire  logic [IN_DATA_W-1:0]  in_data,
  output logic                        out_valid,
  input  wire  logic                  out_ready,
  output logic [OUT_DATA_W-1:0]       out_data
);

  localparam int ZW = $clog2(NUM_ZONES);
  localparam int SW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam int LW = $clog2(MAX_NESTING + 1);

  function automatic logic [ZW-1:0] zone_mod(input logic [ZONE_ID_W-1:0] z);
    logic [63:0] r;
    r = 64'(z);
    for (int k = ZONE_ID_W - 1; k >= 0; k--) begin
      if (r >= (64'(NUM_ZONES) << k)) begin
        r = r - (64'(NUM_ZONES) << k);
      end
    end
    return r[ZW-1:0];
  endfunction

  function automatic logic [DEPTH_W-1:0] depth7(input logic [LW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[DEPTH_W-1:0];
  endfunction

  zent_t              zmem [NUM_ZONES];
  logic [ZW-1:0]      stk_zone [MAX_NESTING];
  logic [TIME_W-1:0]  stk_start [MAX_NESTING];
  logic [TIME_W-1:0]  stk_sinc [MAX_NESTING];

  zent_t              zq_r;
  logic [ZW-1:0]      sq_zone_r;
  logic [TIME_W-1:0]  sq_start_r;
  logic [TIME_W-1:0]  sq_sinc_r;

  cmd_t               cmd_r;
  logic [ZW-1:0]      zone_r;
  logic [TIME_W-1:0]  bytes_r;
  logic [TIME_W-1:0]  now_r;
  logic [LW-1:0]      level_r;
  logic [TIME_W-1:0]  elapsed_r;
  logic [ZW-1:0]      clr_cnt_r;

  status_t            res_status_r;
  zent_t              res_ent_r;
  logic               res_seen_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic               zm_we;
  logic [ZW-1:0]      zm_waddr;
  zent_t              zm_wdata;
  logic               zm_re;
  logic [ZW-1:0]      zm_raddr;
  logic               sk_re;
  logic [LW-1:0]      sk_ridx;
  logic [ZW-1:0]      in_zone;

  assign in_zone = zone_mod(in_data[ZONE_ID_W-1:0]);

  always_comb begin
    zm_we    = 1'b0;
    zm_waddr = zone_r;
    zm_wdata = zq_r;
    if (ctl.clr_wr) begin
      zm_we    = 1'b1;
      zm_waddr = clr_cnt_r;
      zm_wdata = '0;
    end else if (ctl.push) begin
      zm_we = 1'b1;
      if (!zq_r.seen) begin
        zm_wdata.seen  = 1'b1;
        zm_wdata.level = depth7(level_r);
        zm_wdata.bytes = bytes_r;
      end
    end else if (ctl.cur_wr) begin
      zm_we         = 1'b1;
      zm_wdata.hits = zq_r.hits + 64'd1;
      zm_wdata.excl = zq_r.excl + elapsed_r;
      zm_wdata.incl = sq_sinc_r + elapsed_r;
    end else if (ctl.par_wr) begin
      zm_we         = 1'b1;
      zm_waddr      = sq_zone_r;
      zm_wdata.excl = zq_r.excl - elapsed_r;
    end
  end

  assign zm_re    = ctl.accept | ctl.par_zone_rd;
  assign zm_raddr = ctl.accept ? in_zone : sq_zone_r;
  assign sk_re    = ctl.accept | ctl.cur_wr;
  assign sk_ridx  = ctl.accept ? (level_r - LW'(1)) : (level_r - LW'(2));

  always_ff @(posedge clk) begin
    if (zm_we) begin
      zmem[zm_waddr] <= zm_wdata;
    end
    if (zm_re) begin
      zq_r <= zmem[zm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      stk_zone[level_r[SW-1:0]]  <= zone_r;
      stk_start[level_r[SW-1:0]] <= now_r;
      stk_sinc[level_r[SW-1:0]]  <= zq_r.incl;
    end
    if (sk_re) begin
      sq_zone_r  <= stk_zone[sk_ridx[SW-1:0]];
      sq_start_r <= stk_start[sk_ridx[SW-1:0]];
      sq_sinc_r  <= stk_sinc[sk_ridx[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r   <= cmd_t'(in_cmd);
      zone_r  <= in_zone;
      bytes_r <= in_data[ZONE_ID_W +: TIME_W];
      now_r   <= in_data[ZONE_ID_W + TIME_W +: TIME_W];
    end
    if (ctl.pop) begin
      elapsed_r <= now_r - sq_start_r;
    end
    if (ctl.eval) begin
      res_status_r <= ctl.code;
      res_ent_r    <= (cmd_r == CMD_READ) ? zq_r : '0;
      res_seen_r   <= (cmd_r == CMD_NONE) ? 1'b0 : (ctl.push | zq_r.seen);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (ctl.push) begin
        level_r <= level_r + LW'(1);
      end else if (ctl.cur_wr) begin
        level_r <= level_r - LW'(1);
      end
      if (ctl.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + ZW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r <= {7'd0, depth7(level_r), res_seen_r, res_ent_r.level, res_ent_r.bytes,
                     res_ent_r.incl, res_ent_r.excl, res_ent_r.hits, res_status_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.cmd        = cmd_r;
  assign sts.full       = (level_r == LW'(MAX_NESTING));
  assign sts.empty      = (level_r == '0);
  assign sts.mismatch   = (sq_zone_r != zone_r);
  assign sts.has_parent = (level_r >= LW'(2));
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.clr_last   = (clr_cnt_r == ZW'(NUM_ZONES - 1));

`ifndef SYNTH
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(MAX_NESTING))
    else $error("nesting depth beyond stack size");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |=> level_r == $past(level_r) + LW'(1))
    else $error("push did not deepen the stack");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cur_wr |=> level_r == $past(level_r) - LW'(1))
    else $error("end did not pop the stack");

  a_mismatch_end: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.eval && ctl.code == ST_MISMATCH |-> cmd_r == CMD_END)
    else $error("mismatch status on a non-end event");
`endif

endmodule

`default_nettype wire

/* bench/tb_nested_zone_time_profiler_top.sv */
// ----------------------------------------------------------------------------
// Nested zone time profiler testbench
// Sends begin, end, read and unused events with random stalls on both sides,
// predicts every result beat from an internal zone and stack model and
// compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nested_zone_time_profiler_top;
  import nzp_pkg::*;

  localparam int NZONES = 1024;
  localparam int NEST   = 64;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [6:0]       depth;
    logic             seen;
    logic [6:0]       first_lvl;
    logic [63:0]      bytes_tot;
    logic [63:0]      incl;
    logic [63:0]      excl;
    logic [63:0]      hits;
    status_t          status;
  } result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic        zn_seen [NZONES];
  logic [6:0]  zn_level [NZONES];
  logic [63:0] zn_bytes [NZONES];
  logic [63:0] zn_hits [NZONES];
  logic [63:0] zn_excl [NZONES];
  logic [63:0] zn_incl [NZONES];
  logic [9:0]  frm_zone [NEST];
  logic [63:0] frm_start [NEST];
  logic [63:0] frm_saved [NEST];
  int          depth;

  result_t pending_results[$];
  int      fail_count;
  int      cycle_count;
  int      hold_cycles;
  int      beats_taken;
  int      beats_drawn;
  int      ready_wait;
  logic [63:0] clock_now;
  bit      random_stall;

  nested_zone_time_profiler_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic result_t profile_event(cmd_t cmd, logic [9:0] zid,
                                            logic [63:0] nbytes, logic [63:0] stamp);
    result_t r;
    logic [63:0] elapsed;
    int top;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_BEGIN: begin
        if (depth >= NEST) begin
          r.status = ST_FULL;
        end else begin
          if (!zn_seen[zid]) begin
            zn_seen[zid] = 1'b1;
            zn_bytes[zid] = zn_bytes[zid] + nbytes;
            zn_level[zid] = depth[6:0];
          end
          frm_zone[depth] = zid;
          frm_start[depth] = stamp;
          frm_saved[depth] = zn_incl[zid];
          depth++;
        end
      end
      CMD_END: begin
        if (depth == 0) begin
          r.status = ST_EMPTY;
        end else if (frm_zone[depth-1] != zid) begin
          r.status = ST_MISMATCH;
        end else begin
          top = depth - 1;
          elapsed = stamp - frm_start[top];
          if (top > 0) begin
            zn_excl[frm_zone[top-1]] = zn_excl[frm_zone[top-1]] - elapsed;
          end
          zn_excl[zid] = zn_excl[zid] + elapsed;
          zn_incl[zid] = frm_saved[top] + elapsed;
          zn_hits[zid] = zn_hits[zid] + 1;
          depth = top;
        end
      end
      CMD_READ: begin
        r.hits = zn_hits[zid];
        r.excl = zn_excl[zid];
        r.incl = zn_incl[zid];
        r.bytes_tot = zn_bytes[zid];
        r.first_lvl = zn_level[zid];
      end
      default: ;
    endcase
    if (cmd != CMD_NONE) begin
      r.seen = zn_seen[zid];
    end
    r.depth = depth[6:0];
    return r;
  endfunction

  task automatic send_event(cmd_t cmd, logic [9:0] zid, logic [63:0] nbytes,
                            logic [63:0] stamp);
    int gap;
    gap = random_stall ? $urandom_range(0, 8) : 0;
    repeat (gap) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {6'd0, stamp, nbytes, zid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(profile_event(cmd, zid, nbytes, stamp));
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] tick(int lo, int hi);
    clock_now = clock_now + $urandom_range(lo, hi);
    return clock_now;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[272:0];
      beats_taken++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.hits !== want.hits) begin
          $error("hits expected %0h got %0h", want.hits, got.hits);
          fail_count++;
        end
        if (got.excl !== want.excl) begin
          $error("exclusive_time expected %0h got %0h", want.excl, got.excl);
          fail_count++;
        end
        if (got.incl !== want.incl) begin
          $error("inclusive_time expected %0h got %0h", want.incl, got.incl);
          fail_count++;
        end
        if (got.bytes_tot !== want.bytes_tot) begin
          $error("bytes_total expected %0h got %0h", want.bytes_tot, got.bytes_tot);
          fail_count++;
        end
        if (got.first_lvl !== want.first_lvl) begin
          $error("first_level expected %0d got %0d", want.first_lvl, got.first_lvl);
          fail_count++;
        end
        if (got.seen !== want.seen) begin
          $error("was_seen expected %0d got %0d", want.seen, got.seen);
          fail_count++;
        end
        if (got.depth !== want.depth) begin
          $error("open_levels expected %0d got %0d", want.depth, got.depth);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (beats_taken != beats_drawn) begin
      beats_drawn = beats_taken;
      ready_wait = random_stall ? $urandom_range(0, 8) : 0;
    end
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (ready_wait > 0) begin
      out_tready <= 1'b0;
      ready_wait = ready_wait - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_directed;
    send_event(CMD_END, 10'd5, 64'd0, 64'd0);
    send_event(CMD_READ, 10'd1023, 64'd0, 64'd0);
    send_event(CMD_NONE, 10'd3, '1, '1);
    send_event(CMD_BEGIN, 10'd0, '1, 64'd10);
    send_event(CMD_BEGIN, 10'd1023, 64'h5555_aaaa_5555_aaaa, 64'd20);
    send_event(CMD_END, 10'd0, 64'd0, 64'd25);
    send_event(CMD_END, 10'd1023, 64'd0, 64'd50);
    send_event(CMD_BEGIN, 10'd0, 64'd7, '1);
    send_event(CMD_END, 10'd0, 64'd0, 64'd4);
    send_event(CMD_BEGIN, 10'd7, 64'd1, 64'd100);
    send_event(CMD_BEGIN, 10'd7, 64'd2, 64'd110);
    send_event(CMD_END, 10'd7, 64'd0, 64'd130);
    send_event(CMD_END, 10'd7, 64'd0, 64'd170);
    send_event(CMD_READ, 10'd0, 64'd0, 64'd0);
    send_event(CMD_READ, 10'd1023, 64'd0, 64'd0);
    send_event(CMD_READ, 10'd7, 64'd0, 64'd0);
    send_event(CMD_END, 10'd7, 64'd0, 64'd0);
  endtask

  task automatic test_stack_full;
    for (int i = 0; i < NEST + 2; i++) begin
      send_event(CMD_BEGIN, 10'(100 + i), 64'($urandom), tick(1, 50));
    end
    send_event(CMD_READ, 10'd101, 64'd0, 64'd0);
    send_event(CMD_READ, 10'(100 + NEST), 64'd0, 64'd0);
    send_event(CMD_END, 10'd1, 64'd0, tick(1, 9));
    for (int i = NEST - 1; i >= 0; i--) begin
      send_event(CMD_END, 10'(100 + i), 64'd0, tick(1, 50));
    end
  endtask

  task automatic test_backpressure;
    hold_cycles = 200;
    for (int i = 0; i < 20; i++) begin
      send_event(CMD_READ, 10'($urandom), 64'd0, 64'd0);
    end
    wait_drained();
  endtask

  task automatic test_random;
    logic [9:0] open_ids[$];
    logic [9:0] zid;
    int pick;
    for (int n = 0; n < 280; n++) begin
      pick = $urandom_range(0, 99);
      zid = (($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15)));
      if (pick < 40 && open_ids.size() < NEST) begin
        send_event(CMD_BEGIN, zid, {$urandom, $urandom}, tick(0, 1000));
        open_ids.push_back(zid);
      end else if (pick < 75 && open_ids.size() > 0) begin
        send_event(CMD_END, open_ids[$], 64'd0, tick(0, 1000));
        void'(open_ids.pop_back());
      end else if (pick < 90) begin
        send_event(CMD_READ, zid, {$urandom, $urandom}, {$urandom, $urandom});
      end else if (pick < 95) begin
        send_event(CMD_END, zid, 64'd0, {$urandom, $urandom});
        if (open_ids.size() > 0 && open_ids[$] == zid) void'(open_ids.pop_back());
      end else begin
        send_event(CMD_NONE, zid, {$urandom, $urandom}, {$urandom, $urandom});
      end
      if (n == 200) begin
        random_stall = 1'b0;
        wait_drained();
        random_stall = 1'b1;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_NONE;
    out_tready = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    hold_cycles = 0;
    beats_taken = 0;
    beats_drawn = 0;
    ready_wait = 0;
    clock_now = 64'hffff_ffff_ffff_ff00;
    random_stall = 1'b1;
    depth = 0;
    for (int z = 0; z < NZONES; z++) begin
      zn_seen[z] = 1'b0;
      zn_level[z] = '0;
      zn_bytes[z] = '0;
      zn_hits[z] = '0;
      zn_excl[z] = '0;
      zn_incl[z] = '0;
    end
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_stack_full();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
